[hw/rtl/ipsc_pkg.sv]
package ipsc_pkg;

	// Input function codes
	localparam logic [3:0] FUNC_TICK        = 4'd0;
	localparam logic [3:0] FUNC_BUTTON      = 4'd1;
	localparam logic [3:0] FUNC_ROTARY      = 4'd2;
	localparam logic [3:0] FUNC_TIMER       = 4'd3;
	localparam logic [3:0] FUNC_SET_HEATER  = 4'd4;
	localparam logic [3:0] FUNC_FORCE_DISP  = 4'd5;
	localparam logic [3:0] FUNC_FORCE_LIGHT = 4'd6;
	localparam logic [3:0] FUNC_FORCE_DEEP  = 4'd7;
	localparam logic [3:0] FUNC_FORCE_WAKE  = 4'd8;

	// Power states
	localparam logic [1:0] PWR_ACTIVE      = 2'd0;
	localparam logic [1:0] PWR_DISPLAY_OFF = 2'd1;
	localparam logic [1:0] PWR_LIGHT       = 2'd2;
	localparam logic [1:0] PWR_DEEP        = 2'd3;

	// Wake reasons
	localparam logic [1:0] RSN_UNKNOWN = 2'd0;
	localparam logic [1:0] RSN_BUTTON  = 2'd1;
	localparam logic [1:0] RSN_ROTARY  = 2'd2;
	localparam logic [1:0] RSN_TIMER   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_SLEEP_EN      = 2'd0;
	localparam logic [1:0] CFG_DISPLAY_OFF   = 2'd1;
	localparam logic [1:0] CFG_LIGHT_SLEEP   = 2'd2;
	localparam logic [1:0] CFG_DEEP_SLEEP    = 2'd3;

	// Configuration reset values
	localparam logic [31:0] DISPLAY_OFF_RESET = 32'd30000;
	localparam logic [31:0] LIGHT_SLEEP_RESET = 32'd60000;
	localparam logic [31:0] DEEP_SLEEP_RESET  = 32'd300000;

	typedef struct packed {
		logic [3:0] func;
		logic       heater_on;
	} item_t;

	typedef struct packed {
		logic [1:0]  power_state;
		logic [1:0]  wake_reason;
		logic [31:0] idle_time;
		logic [31:0] since_wake_time;
	} result_t;

	typedef struct packed {
		logic        sleep_en;
		logic [31:0] display_off_timeout;
		logic [31:0] light_sleep_timeout;
		logic [31:0] deep_sleep_timeout;
		logic        sleep_off;
	} cfg_t;

	// Saturating increment of a 32-bit counter
	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		logic [31:0] r;
		if (v == 32'hFFFF_FFFF) begin
			r = v;
		end else begin
			r = v + 32'd1;
		end
		return r;
	endfunction

endpackage

[hw/rtl/ipsc_cfg.sv]
module ipsc_cfg
	import ipsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	logic        sleep_en_q;
	logic [31:0] display_off_q;
	logic [31:0] light_sleep_q;
	logic [31:0] deep_sleep_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_en_q    <= 1'b1;
			display_off_q <= DISPLAY_OFF_RESET;
			light_sleep_q <= LIGHT_SLEEP_RESET;
			deep_sleep_q  <= DEEP_SLEEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLEEP_EN:    sleep_en_q    <= cfg_data[0];
				CFG_DISPLAY_OFF: display_off_q <= cfg_data;
				CFG_LIGHT_SLEEP: light_sleep_q <= cfg_data;
				CFG_DEEP_SLEEP:  deep_sleep_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Flag a write that turns sleep off; the core wakes on it
	assign cfg.sleep_off = cfg_we && (cfg_index == CFG_SLEEP_EN) && !cfg_data[0];
	assign cfg.sleep_en            = sleep_en_q;
	assign cfg.display_off_timeout = display_off_q;
	assign cfg.light_sleep_timeout = light_sleep_q;
	assign cfg.deep_sleep_timeout  = deep_sleep_q;

endmodule

[hw/rtl/ipsc_core.sv]
module ipsc_core
	import ipsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    proc,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [1:0]  mode_q;
	logic [1:0]  reason_q;
	logic        heater_q;
	logic [31:0] idle_q;
	logic [31:0] wake_q;

	logic [1:0]  mode_d;
	logic [1:0]  reason_d;
	logic        heater_d;
	logic [31:0] idle_d;
	logic [31:0] wake_d;
	logic [31:0] idle_inc;
	logic [1:0]  target;

	assign idle_inc = sat_inc(idle_q);

	// Pick the tick target by priority
	always_comb begin
		if (!heater_q && (idle_inc > cfg.deep_sleep_timeout)) begin
			target = PWR_DEEP;
		end else if (idle_inc > cfg.light_sleep_timeout) begin
			target = PWR_LIGHT;
		end else if (idle_inc > cfg.display_off_timeout) begin
			target = PWR_DISPLAY_OFF;
		end else begin
			target = PWR_ACTIVE;
		end
	end

	// Apply one request to the state
	always_comb begin
		mode_d   = mode_q;
		reason_d = reason_q;
		heater_d = heater_q;
		idle_d   = idle_q;
		wake_d   = wake_q;
		if (proc) begin
			unique case (item.func)
				FUNC_TICK: begin
					idle_d = idle_inc;
					wake_d = sat_inc(wake_q);
					if (!cfg.sleep_en) begin
						mode_d = PWR_ACTIVE;
					end else if (target != mode_q) begin
						mode_d = target;
						if (target == PWR_ACTIVE) begin
							wake_d = '0;
						end
					end
				end
				FUNC_BUTTON, FUNC_ROTARY, FUNC_TIMER: begin
					reason_d = item.func[1:0];
					idle_d   = '0;
					if (mode_q != PWR_ACTIVE) begin
						mode_d = PWR_ACTIVE;
						wake_d = '0;
					end
				end
				FUNC_SET_HEATER: begin
					heater_d = item.heater_on;
					if (item.heater_on && (mode_q == PWR_DEEP)) begin
						mode_d = PWR_ACTIVE;
						wake_d = '0;
					end
				end
				FUNC_FORCE_DISP: begin
					if (cfg.sleep_en) begin
						mode_d = PWR_DISPLAY_OFF;
					end
				end
				FUNC_FORCE_LIGHT: begin
					if (cfg.sleep_en) begin
						mode_d = PWR_LIGHT;
					end
				end
				FUNC_FORCE_DEEP: begin
					if (cfg.sleep_en) begin
						mode_d = heater_q ? PWR_LIGHT : PWR_DEEP;
					end
				end
				FUNC_FORCE_WAKE: begin
					if (mode_q != PWR_ACTIVE) begin
						mode_d = PWR_ACTIVE;
						wake_d = '0;
					end
				end
				default: ;
			endcase
		end
		// Wake at once when sleep is turned off
		if (cfg.sleep_off && (mode_d != PWR_ACTIVE)) begin
			mode_d = PWR_ACTIVE;
			wake_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= PWR_ACTIVE;
			reason_q <= RSN_UNKNOWN;
			heater_q <= 1'b0;
			idle_q   <= '0;
			wake_q   <= '0;
		end else begin
			mode_q   <= mode_d;
			reason_q <= reason_d;
			heater_q <= heater_d;
			idle_q   <= idle_d;
			wake_q   <= wake_d;
		end
	end

	// Report the state after the update
	assign res.power_state     = mode_d;
	assign res.wake_reason     = reason_d;
	assign res.idle_time       = idle_d;
	assign res.since_wake_time = wake_d;

endmodule

[hw/rtl/inactivity_power_state_controller_top.sv]
// Inactivity power-state controller.
// Request channel: item_valid / item_stall / item carry one request per
// accepted cycle: a one-millisecond tick or an event (button, rotary, timer,
// heater update, force commands). Result channel: result_valid /
// result_stall / result return exactly one result per request, in order:
// power state, wake reason, idle time and time since wake.
// Path: an accepted request is latched in the input stage, then applied to
// the state and its result loaded into the result register once that
// register is free; the result is shown from then on.
// Throughput: one request per cycle while result_stall is low; the state
// update between the input stage and the result register is combinational.
// When result_stall is high the result holds; an empty input stage still
// takes one more request, then item_stall rises until the result drains.
// Configuration: cfg_we / cfg_index / cfg_data write one register per cycle.
// Reset: the block is active, reason unknown, heater off, counters zero,
// timeouts 30000 / 60000 / 300000 ms and sleep enabled.
module inactivity_power_state_controller_top
	import ipsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    adv_s1;
	logic    proc;

	ipsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Result register frees when empty or taken
	assign adv_s2     = !valid_s2 || !result_stall;
	assign proc       = valid_s1 && adv_s2;
	assign adv_s1     = !valid_s1 || adv_s2;
	assign item_stall = !adv_s1;

	ipsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.proc   (proc),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			result_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

[verif/inactivity_power_state_controller_top_test.sv]
`timescale 1ns / 1ps

module inactivity_power_state_controller_top_test;
	import ipsc_pkg::*;

	localparam int unsigned RESET_CYCLES     = 7;
	localparam int unsigned SETTLE_CYCLES    = 6;
	localparam int unsigned WATCHDOG_LIMIT   = 5000;
	localparam int unsigned RANDOM_PHASES    = 9;
	localparam int unsigned RANDOM_PER_PHASE = 125;
	localparam int unsigned MAX_GAP          = 12;
	localparam int unsigned MAX_TICK_RUN     = 20;
	localparam logic [3:0]  FUNC_UNUSED_LO   = 4'd9;
	localparam logic [3:0]  FUNC_UNUSED_HI   = 4'd15;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Requests waiting to be driven and status words waiting to come back
	item_t       queued_requests[$];
	result_t     pending_status[$];
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned sender_max = MAX_GAP;
	int unsigned receiver_max = MAX_GAP;
	int unsigned mismatches = 0;

	// Shadow copy of the controller state and its registers
	logic        sleep_allowed = 1'b1;
	logic [31:0] display_off_ms = DISPLAY_OFF_RESET;
	logic [31:0] light_sleep_ms = LIGHT_SLEEP_RESET;
	logic [31:0] deep_sleep_ms = DEEP_SLEEP_RESET;
	logic [1:0]  pwr_mode = PWR_ACTIVE;
	logic [1:0]  wake_src = RSN_UNKNOWN;
	logic        heater_running = 1'b0;
	logic [31:0] idle_ms = '0;
	logic [31:0] awake_ms = '0;

	inactivity_power_state_controller_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	// Leave any sleep state and restart the since-wake counter
	function automatic void wake_up();
		if (pwr_mode != PWR_ACTIVE) begin
			pwr_mode = PWR_ACTIVE;
			awake_ms = '0;
		end
	endfunction

	// Apply one request to the shadow state and return the status it reports
	function automatic result_t next_status(input item_t req);
		result_t     st;
		logic [1:0]  target;
		case (req.func)
			FUNC_TICK: begin
				idle_ms = bump(idle_ms);
				awake_ms = bump(awake_ms);
				if (!sleep_allowed) begin
					pwr_mode = PWR_ACTIVE;
				end else begin
					if (!heater_running && idle_ms > deep_sleep_ms) begin
						target = PWR_DEEP;
					end else if (idle_ms > light_sleep_ms) begin
						target = PWR_LIGHT;
					end else if (idle_ms > display_off_ms) begin
						target = PWR_DISPLAY_OFF;
					end else begin
						target = PWR_ACTIVE;
					end
					if (target == PWR_ACTIVE) begin
						wake_up();
					end else begin
						pwr_mode = target;
					end
				end
			end
			FUNC_BUTTON, FUNC_ROTARY, FUNC_TIMER: begin
				case (req.func)
					FUNC_BUTTON: wake_src = RSN_BUTTON;
					FUNC_ROTARY: wake_src = RSN_ROTARY;
					default:     wake_src = RSN_TIMER;
				endcase
				idle_ms = '0;
				wake_up();
			end
			FUNC_SET_HEATER: begin
				heater_running = req.heater_on;
				if (req.heater_on && pwr_mode == PWR_DEEP) begin
					wake_up();
				end
			end
			FUNC_FORCE_DISP: begin
				if (sleep_allowed) begin
					pwr_mode = PWR_DISPLAY_OFF;
				end
			end
			FUNC_FORCE_LIGHT: begin
				if (sleep_allowed) begin
					pwr_mode = PWR_LIGHT;
				end
			end
			FUNC_FORCE_DEEP: begin
				if (sleep_allowed) begin
					pwr_mode = heater_running ? PWR_LIGHT : PWR_DEEP;
				end
			end
			FUNC_FORCE_WAKE: begin
				wake_up();
			end
			default: begin
			end
		endcase
		st.power_state = pwr_mode;
		st.wake_reason = wake_src;
		st.idle_time = idle_ms;
		st.since_wake_time = awake_ms;
		return st;
	endfunction

	// Request driver: hold while stalled, wait out the drawn gap, then send
	always @(posedge clk or negedge arst_n) begin : request_driver
		int unsigned gap_now;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			send_gap <= 0;
		end else begin
			gap_now = send_gap;
			if (item_valid && !item_stall) begin
				pending_status.push_back(next_status(item));
				gap_now = $urandom_range(0, sender_max);
			end
			if (!item_valid || !item_stall) begin
				if (gap_now == 0 && queued_requests.size() != 0) begin
					item <= queued_requests.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
					if (gap_now != 0) begin
						gap_now--;
					end
				end
			end
			send_gap <= gap_now;
		end
	end

	// Status monitor: compare each accepted status, then draw the next stall
	always @(posedge clk or negedge arst_n) begin : status_monitor
		int unsigned stall_now;
		result_t     want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			stall_now = stall_left;
			if (result_valid && !result_stall) begin
				if (pending_status.size() == 0) begin
					$error("status returned with no request outstanding");
					mismatches++;
				end else begin
					want = pending_status.pop_front();
					if (result.power_state !== want.power_state) begin
						$error("power_state: expected %0d, got %0d",
							want.power_state, result.power_state);
						mismatches++;
					end
					if (result.wake_reason !== want.wake_reason) begin
						$error("wake_reason: expected %0d, got %0d",
							want.wake_reason, result.wake_reason);
						mismatches++;
					end
					if (result.idle_time !== want.idle_time) begin
						$error("idle_time: expected %0d, got %0d",
							want.idle_time, result.idle_time);
						mismatches++;
					end
					if (result.since_wake_time !== want.since_wake_time) begin
						$error("since_wake_time: expected %0d, got %0d",
							want.since_wake_time, result.since_wake_time);
						mismatches++;
					end
				end
				stall_now = $urandom_range(0, receiver_max);
			end else if (stall_now != 0) begin
				stall_now--;
			end
			result_stall <= (stall_now != 0);
			stall_left <= stall_now;
		end
	end

	// End the run when neither channel moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("inactivity_power_state_controller_top regression: fail");
		$finish;
	end

	task automatic queue_request(input logic [3:0] f, input logic h);
		item_t r;
		r.func = f;
		r.heater_on = h;
		queued_requests.push_back(r);
	endtask

	// Write one register and mirror it in the shadow copy
	task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SLEEP_EN: begin
				sleep_allowed = value[0];
				if (!sleep_allowed) begin
					wake_up();
				end
			end
			CFG_DISPLAY_OFF: display_off_ms = value;
			CFG_LIGHT_SLEEP: light_sleep_ms = value;
			default:         deep_sleep_ms = value;
		endcase
	endtask

	// Wait until every request is sent and every status has come back
	task automatic settle_block();
		do begin
			@(negedge clk);
		end while (queued_requests.size() != 0 || item_valid || pending_status.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Tick runs closed by one request of any code, so the timeouts are actually crossed
	task automatic queue_random_traffic(input int unsigned count);
		int unsigned made;
		int unsigned run;
		int unsigned pick;
		logic [3:0]  f;
		made = 0;
		while (made < count) begin
			run = $urandom_range(0, MAX_TICK_RUN);
			repeat (run) queue_request(FUNC_TICK, 1'($urandom_range(0, 1)));
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				f = 4'($urandom_range(FUNC_BUTTON, FUNC_TIMER));
			end else if (pick < 50) begin
				f = FUNC_SET_HEATER;
			end else if (pick < 75) begin
				f = 4'($urandom_range(FUNC_FORCE_DISP, FUNC_FORCE_WAKE));
			end else if (pick < 85) begin
				f = 4'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
			end else begin
				f = FUNC_TICK;
			end
			queue_request(f, 1'($urandom_range(0, 1)));
			made += run + 1;
		end
	endtask

	initial begin : sequencer
		logic        en;
		logic [31:0] enable_word;
		logic [31:0] disp;
		logic [31:0] light;
		logic [31:0] deep;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk every event and command at reset timeouts
		queue_request(FUNC_TICK, 1'b0);
		queue_request(FUNC_BUTTON, 1'b1);
		queue_request(FUNC_ROTARY, 1'b0);
		queue_request(FUNC_TIMER, 1'b1);
		queue_request(FUNC_FORCE_DISP, 1'b0);
		queue_request(FUNC_TICK, 1'b1);
		queue_request(FUNC_FORCE_LIGHT, 1'b0);
		queue_request(FUNC_FORCE_DEEP, 1'b1);
		queue_request(FUNC_SET_HEATER, 1'b1);
		queue_request(FUNC_FORCE_DEEP, 1'b0);
		queue_request(FUNC_SET_HEATER, 1'b0);
		queue_request(FUNC_FORCE_DEEP, 1'b0);
		queue_request(FUNC_SET_HEATER, 1'b0);
		queue_request(FUNC_FORCE_WAKE, 1'b1);
		queue_request(FUNC_UNUSED_LO, 1'b1);
		queue_request(FUNC_UNUSED_HI, 1'b0);
		queue_request(FUNC_FORCE_LIGHT, 1'b1);
		settle_block();

		// Disable sleep while in light sleep: the block must wake at once
		program_register(CFG_DISPLAY_OFF, 32'd0);
		program_register(CFG_LIGHT_SLEEP, 32'd0);
		program_register(CFG_DEEP_SLEEP, 32'd0);
		program_register(CFG_SLEEP_EN, 32'd0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		queue_request(FUNC_TICK, 1'b0);
		queue_request(FUNC_FORCE_DEEP, 1'b1);
		queue_request(FUNC_TICK, 1'b1);
		queue_request(FUNC_FORCE_LIGHT, 1'b0);
		queue_request(FUNC_FORCE_DISP, 1'b1);
		settle_block();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			en = 1'b1;
			case (phase)
				0: begin disp = 32'd3; light = 32'd7; deep = 32'd12; end
				1: begin disp = 32'd0; light = 32'd0; deep = 32'd0; end
				2: begin disp = '1; light = '1; deep = '1; end
				3: begin disp = 32'd12; light = 32'd6; deep = 32'd3; end
				4: begin en = 1'b0; disp = 32'd1; light = 32'd2; deep = 32'd3; end
				5: begin
					disp = $urandom_range(0, 20);
					light = $urandom_range(0, 20);
					deep = $urandom_range(0, 20);
				end
				6: begin disp = 32'd5; light = '1; deep = 32'd9; end
				7: begin disp = 32'd2; light = 32'd4; deep = 32'd8; end
				default: begin
					disp = $urandom;
					light = $urandom_range(0, 15);
					deep = $urandom_range(0, 25);
				end
			endcase
			enable_word = $urandom;
			enable_word[0] = en;
			program_register(CFG_DISPLAY_OFF, disp);
			program_register(CFG_LIGHT_SLEEP, light);
			program_register(CFG_DEEP_SLEEP, deep);
			program_register(CFG_SLEEP_EN, enable_word);
			repeat (SETTLE_CYCLES) @(negedge clk);

			sender_max = (phase % 3 == 1) ? 0 : MAX_GAP;
			receiver_max = (phase % 4 == 2) ? 0 : MAX_GAP;
			queue_random_traffic(RANDOM_PER_PHASE);
			// Leave the block asleep so the next register write lands on a sleep state
			if (en) begin
				queue_request(4'($urandom_range(FUNC_FORCE_DISP, FUNC_FORCE_DEEP)), 1'b0);
			end
			settle_block();
		end

		if (mismatches == 0) begin
			$display("inactivity_power_state_controller_top regression: pass");
		end else begin
			$display("inactivity_power_state_controller_top regression: fail");
		end
		$finish;
	end

endmodule
